### rtl/rlcm_pkg.sv
// ----------------------------------------------------------------------------
// rlcm_pkg
// shared types for the running hyperperiod (lcm) core: sequencer states and
// the operation codes of the shared add/subtract unit
// ----------------------------------------------------------------------------
`default_nettype none

package rlcm_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  // shared unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

`default_nettype wire

### rtl/rlcm_if.sv
// ----------------------------------------------------------------------------
// rlcm_if
// valid/ready channels of the running hyperperiod core: period items in,
// hyperperiod items out
// ----------------------------------------------------------------------------
`default_nettype none

interface rlcm_in_if #(
  parameter int PERIOD_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [PERIOD_WIDTH-1:0] period;
  logic                    first;

  modport source (output valid, output period, output first, input ready);
  modport sink   (input valid, input period, input first, output ready);
endinterface

interface rlcm_out_if #(
  parameter int HYPER_WIDTH = 63
);
  logic                   valid;
  logic                   ready;
  logic [HYPER_WIDTH-1:0] hyper_period;
  logic                   overflow;

  modport source (output valid, output hyper_period, output overflow, input ready);
  modport sink   (input valid, input hyper_period, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/rlcm_alu.sv
// ----------------------------------------------------------------------------
// rlcm_alu
// shared add/subtract unit; on subtract, borrow flags x < y
// ----------------------------------------------------------------------------
`default_nettype none

module rlcm_alu #(
  parameter int WIDTH = 65
) (
  input  var rlcm_pkg::alu_op_t op,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  output logic      [WIDTH-1:0] res,
  output logic                  borrow
);

  logic [WIDTH:0] full;

  always_comb begin
    unique case (op)
      rlcm_pkg::ALU_ADD: full = {1'b0, x} + {1'b0, y};
      rlcm_pkg::ALU_SUB: full = {1'b0, x} - {1'b0, y};
      default:           full = '0;
    endcase
  end

  assign res    = full[WIDTH-1:0];
  assign borrow = (op == rlcm_pkg::ALU_SUB) && full[WIDTH];

endmodule

`default_nettype wire

### rtl/running_lcm_hyperperiod_core.sv
// ----------------------------------------------------------------------------
// running_lcm_hyperperiod_core
// running least common multiple (hyperperiod) of a stream of task periods
// ----------------------------------------------------------------------------
// Each input item carries a period and a first mark. A first item starts a new
// set with that period; every other period is folded into the running value as
// (r / gcd(r, p)) * p, and each item answers with one output item holding the
// hyperperiod so far and a sticky overflow flag (value saturated to all ones).
// One item at a time is worked on by a small sequencer around a single shared
// add/subtract unit: binary gcd (one shift, swap or subtract per cycle), a
// restoring division over W = max(HYPER_WIDTH, PERIOD_WIDTH) quotient bits
// and a shift-add multiply over at most PERIOD_WIDTH period bits. A first
// item, a zero operand or an item after overflow skips these steps and goes
// straight to the result. in_ch.ready is high only while the sequencer is
// idle; a finished result sits in an output register, so the next item can be
// taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module running_lcm_hyperperiod_core #(
  parameter int PERIOD_WIDTH = 32,
  parameter int HYPER_WIDTH  = 63
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rlcm_in_if.sink   in_ch,
  rlcm_out_if.source out_ch
);

  // working width of the gcd and division datapath
  localparam int W  = (HYPER_WIDTH > PERIOD_WIDTH) ? HYPER_WIDTH : PERIOD_WIDTH;
  // shared unit width: covers W+1 bit division and HYPER_WIDTH+2 bit products
  localparam int AW = W + 2;
  localparam int CW = $clog2(W);

  localparam logic [HYPER_WIDTH-1:0] HYPER_MAX = '1;
  localparam logic [CW-1:0]          DIV_LAST  = CW'(W - 1);
  localparam logic [CW-1:0]          MUL_LAST  = CW'(PERIOD_WIDTH - 1);

  // control state
  rlcm_pkg::state_t state_r, state_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // datapath
  logic [HYPER_WIDTH-1:0]  lcm_r, lcm_nxt;
  logic [W-1:0]            a_r, a_nxt;     // gcd operand, then divisor
  logic [W-1:0]            b_r, b_nxt;     // gcd operand
  logic [W-1:0]            rs_r, rs_nxt;   // r shifted by common twos, then quotient
  logic [W-1:0]            rem_r, rem_nxt; // division remainder
  logic [PERIOD_WIDTH-1:0] p_r, p_nxt;     // multiplier bits, msb first
  logic [HYPER_WIDTH-1:0]  acc_r, acc_nxt; // product so far
  logic [HYPER_WIDTH-1:0]  out_hyp_r, out_hyp_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  // shared unit
  rlcm_pkg::alu_op_t alu_op;
  logic [AW-1:0]     alu_x, alu_y, alu_res;
  logic              alu_borrow;

  rlcm_alu #(
    .WIDTH (AW)
  ) u_alu (
    .op     (alu_op),
    .x      (alu_x),
    .y      (alu_y),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  logic [W-1:0] p_ext;
  logic [W:0]   div_t;

  assign p_ext = W'(in_ch.period);
  assign div_t = {rem_r, rs_r[W-1]};

  assign in_ch.ready         = (state_r == rlcm_pkg::ST_IDLE);
  assign out_ch.valid        = out_vld_r;
  assign out_ch.hyper_period = out_hyp_r;
  assign out_ch.overflow     = out_ovf_r;

  // operand selection for the shared unit
  always_comb begin
    alu_op = rlcm_pkg::ALU_SUB;
    alu_x  = '0;
    alu_y  = '0;
    unique case (state_r)
      rlcm_pkg::ST_GCD: begin
        alu_x = AW'(a_r);
        alu_y = AW'(b_r);
      end
      rlcm_pkg::ST_DIV: begin
        alu_x = AW'(div_t);
        alu_y = AW'(a_r);
      end
      rlcm_pkg::ST_MUL: begin
        alu_op = rlcm_pkg::ALU_ADD;
        alu_x  = AW'({acc_r, 1'b0});
        alu_y  = p_r[PERIOD_WIDTH-1] ? AW'(rs_r) : '0;
      end
      default: begin
        alu_op = rlcm_pkg::ALU_SUB;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    ovf_nxt     = ovf_r;
    out_vld_nxt = out_vld_r;
    cnt_nxt     = cnt_r;
    lcm_nxt     = lcm_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    rs_nxt      = rs_r;
    rem_nxt     = rem_r;
    p_nxt       = p_r;
    acc_nxt     = acc_r;
    out_hyp_nxt = out_hyp_r;
    out_ovf_nxt = out_ovf_r;

    // output register drains independently of the sequencer
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      rlcm_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.first) begin
            // new set: load the period, saturate if it does not fit
            if (p_ext > W'(HYPER_MAX)) begin
              lcm_nxt = HYPER_MAX;
              ovf_nxt = 1'b1;
            end else begin
              lcm_nxt = p_ext[HYPER_WIDTH-1:0];
              ovf_nxt = 1'b0;
            end
            state_nxt = rlcm_pkg::ST_DONE;
          end else if (ovf_r) begin
            // set already overflowed: value held
            state_nxt = rlcm_pkg::ST_DONE;
          end else if (lcm_r == '0 || p_ext == '0) begin
            // zero is the lcm of anything with zero
            lcm_nxt   = '0;
            state_nxt = rlcm_pkg::ST_DONE;
          end else begin
            a_nxt     = W'(lcm_r);
            b_nxt     = p_ext;
            rs_nxt    = W'(lcm_r);
            p_nxt     = in_ch.period;
            state_nxt = rlcm_pkg::ST_GCD;
          end
        end
      end

      rlcm_pkg::ST_GCD: begin
        if (b_r == '0) begin
          // a holds the odd part of the gcd, rs the dividend without common twos
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = rlcm_pkg::ST_DIV;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt  = a_r >> 1;
          b_nxt  = b_r >> 1;
          rs_nxt = rs_r >> 1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (alu_borrow) begin
          // both odd, a below b: swap, subtract next cycle
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = b_r;
          b_nxt = alu_res[W-1:0];
        end
      end

      rlcm_pkg::ST_DIV: begin
        // restoring division, one quotient bit a cycle
        if (alu_borrow) begin
          rem_nxt = div_t[W-1:0];
        end else begin
          rem_nxt = alu_res[W-1:0];
        end
        rs_nxt  = {rs_r[W-2:0], !alu_borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = rlcm_pkg::ST_MUL;
        end
      end

      rlcm_pkg::ST_MUL: begin
        // shift-add multiply, quotient times period, msb first
        p_nxt   = p_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (alu_res[AW-1:HYPER_WIDTH] != '0) begin
          lcm_nxt   = HYPER_MAX;
          ovf_nxt   = 1'b1;
          state_nxt = rlcm_pkg::ST_DONE;
        end else begin
          acc_nxt = alu_res[HYPER_WIDTH-1:0];
          if (cnt_r == MUL_LAST) begin
            lcm_nxt   = alu_res[HYPER_WIDTH-1:0];
            state_nxt = rlcm_pkg::ST_DONE;
          end
        end
      end

      rlcm_pkg::ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_hyp_nxt = lcm_r;
          out_ovf_nxt = ovf_r;
          state_nxt   = rlcm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = rlcm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rlcm_pkg::ST_IDLE;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      lcm_r     <= HYPER_WIDTH'(1);
    end else begin
      state_r   <= state_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
      lcm_r     <= lcm_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    rs_r      <= rs_nxt;
    rem_r     <= rem_nxt;
    p_r       <= p_nxt;
    acc_r     <= acc_nxt;
    out_hyp_r <= out_hyp_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // an accepted item always moves the sequencer out of idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != rlcm_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting an item");

  // an overflowed result is always saturated
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ovf_r) |-> (out_hyp_r == HYPER_MAX))
    else $error("overflow flagged without saturated hyperperiod");

  // divisor holds through the division
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcm_pkg::ST_DIV && $past(state_r) == rlcm_pkg::ST_DIV) |-> $stable(a_r))
    else $error("divisor changed during division");

  // the gcd phase ends with an odd divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rlcm_pkg::ST_DIV) |-> a_r[0])
    else $error("even divisor entering division");

endmodule

`default_nettype wire
